// ----- hdl/psc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pressure, temperature and humidity compensation: shared definitions
// Payload types, calibration register indexes, constants of the integer
// formulas and the helpers used to split 64-bit products into 32-bit parts.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int unsigned DW     = 64;  // width of the pressure datapath
  localparam int unsigned CFG_IW = 3;   // width of the register index

  typedef enum logic [CFG_IW-1:0] {
    CFG_TEMP    = 3'd0,
    CFG_PRESS_A = 3'd1,
    CFG_PRESS_B = 3'd2,
    CFG_MIXED   = 3'd3,
    CFG_HUM     = 3'd4
  } cfg_idx_e;

  localparam logic [32:0]   P_OFS    = 33'd128000;
  localparam logic [20:0]   PN_FULL  = 21'd1048576;
  localparam logic [63:0]   P_SCALE  = 64'd3125;
  localparam logic [63:0]   V1_BIAS  = 64'h0000_8000_0000_0000;
  localparam logic [31:0]   TC_RND   = 32'd128;
  localparam logic [31:0]   H_OFS    = 32'd76800;
  localparam logic [31:0]   HUM_MAX  = 32'd419430400;
  localparam logic [31:0]   E_OFS    = 32'd2097152;
  localparam logic [31:0]   X_RND    = 32'd16384;
  localparam logic [31:0]   C_OFS    = 32'd32768;
  localparam logic [31:0]   G_RND    = 32'd8192;
  localparam logic [16:0]   HUM_OUT_MAX = 17'd102400;

  typedef struct packed {
    logic [19:0] adc_temp;
    logic [19:0] adc_press;
    logic [15:0] adc_hum;
  } req_t;

  typedef struct packed {
    logic signed [31:0] temp_centi;
    logic signed [31:0] fine_temp;
    logic [31:0]        press_q8;
    logic [16:0]        hum_q10;
    logic               press_div_zero;
  } res_t;

  // Partial products of a wrapped 64 x 64 multiply: low half product and
  // the low 32 bits of the two cross terms.
  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] cr;
  } pp_t;

  function automatic pp_t mul64_pp(input logic [63:0] a, input logic [63:0] b);
    pp_t r;
    r.ll = a[31:0] * b[31:0];
    r.cr = a[31:0] * b[63:32] + a[63:32] * b[31:0];
    return r;
  endfunction

  function automatic logic [63:0] pp_sum(input pp_t p);
    return p.ll + {p.cr, 32'd0};
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned sh);
    return $signed(v) >>> sh;
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] v, input int unsigned sh);
    return $signed(v) >>> sh;
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage
`default_nettype wire

// ----- hdl/psc_sdiv.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined signed divider
// Truncating two's complement division, one quotient bit per stage. The
// most negative dividend over minus one wraps; a zero divisor is flagged.
// ----------------------------------------------------------------------------
module psc_sdiv (
  input  logic                   clk_i,
  input  logic [psc_pkg::DW-1:0] num_i,
  input  logic [psc_pkg::DW-1:0] den_i,
  output logic [psc_pkg::DW-1:0] quo_o,
  output logic                   dz_o
);
  import psc_pkg::*;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [DW-1:0] nq;   // dividend bits shift out, quotient bits shift in
    logic [DW-1:0] ud;
    logic          neg;
    logic          dz;
  } dstg_t;

  dstg_t         st_q [0:DW];
  logic [DW:0]   shf_w [1:DW];
  logic [DW:0]   dif_w [1:DW];
  logic [DW-1:0] quo_q;
  logic          dz_q;

  always_comb begin
    for (int k = 1; k <= DW; k++) begin
      shf_w[k] = {st_q[k-1].rem, st_q[k-1].nq[DW-1]};
      dif_w[k] = shf_w[k] - {1'b0, st_q[k-1].ud};
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0].rem <= '0;
    st_q[0].nq  <= num_i[DW-1] ? (~num_i + 1'b1) : num_i;
    st_q[0].ud  <= den_i[DW-1] ? (~den_i + 1'b1) : den_i;
    st_q[0].neg <= num_i[DW-1] ^ den_i[DW-1];
    st_q[0].dz  <= (den_i == '0);
    for (int k = 1; k <= DW; k++) begin
      // A clear borrow bit means the shifted remainder reached the divisor.
      st_q[k].rem <= dif_w[k][DW] ? shf_w[k][DW-1:0] : dif_w[k][DW-1:0];
      st_q[k].nq  <= {st_q[k-1].nq[DW-2:0], ~dif_w[k][DW]};
      st_q[k].ud  <= st_q[k-1].ud;
      st_q[k].neg <= st_q[k-1].neg;
      st_q[k].dz  <= st_q[k-1].dz;
    end
    quo_q <= st_q[DW].neg ? (~st_q[DW].nq + 1'b1) : st_q[DW].nq;
    dz_q  <= st_q[DW].dz;
  end

  assign quo_o = quo_q;
  assign dz_o  = dz_q;

endmodule
`default_nettype wire

// ----- hdl/pth_sensor_compensation.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pressure, temperature and humidity compensation pipeline
// The 64 stages of the pressure divider set most of the pipeline depth.
// Throughput: one reading per clock cycle, busy_o never rises.
// Reset clears the valid line and all calibration registers to zero.
// Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module pth_sensor_compensation (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  psc_pkg::req_t              req_i,
  output logic                       res_valid_o,
  output psc_pkg::res_t              res_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [psc_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [63:0]                cfg_data_i
);
  import psc_pkg::*;

  localparam int unsigned NSTG = 84;

  typedef struct packed {
    logic [31:0] tc;
    logic [31:0] fine;
  } tf_t;

  typedef struct packed {
    logic [31:0] tc;
    logic [31:0] fine;
    logic [16:0] hum;
  } side_t;

  // Calibration registers
  logic [47:0] cal_temp_q;
  logic [63:0] cal_press_a_q;
  logic [63:0] cal_press_b_q;
  logic [47:0] cal_mixed_q;
  logic [31:0] cal_hum_q;

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
  logic [7:0]         h1, h3;
  logic signed [11:0] h4, h5;
  logic signed [7:0]  h6;

  assign t1 = cal_temp_q[15:0];
  assign t2 = cal_temp_q[31:16];
  assign t3 = cal_temp_q[47:32];
  assign p1 = cal_press_a_q[15:0];
  assign p2 = cal_press_a_q[31:16];
  assign p3 = cal_press_a_q[47:32];
  assign p4 = cal_press_a_q[63:48];
  assign p5 = cal_press_b_q[15:0];
  assign p6 = cal_press_b_q[31:16];
  assign p7 = cal_press_b_q[47:32];
  assign p8 = cal_press_b_q[63:48];
  assign p9 = cal_mixed_q[15:0];
  assign h1 = cal_mixed_q[23:16];
  assign h2 = cal_mixed_q[39:24];
  assign h3 = cal_mixed_q[47:40];
  assign h4 = cal_hum_q[11:0];
  assign h5 = cal_hum_q[23:12];
  assign h6 = cal_hum_q[31:24];

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_temp_q    <= '0;
      cal_press_a_q <= '0;
      cal_press_b_q <= '0;
      cal_mixed_q   <= '0;
      cal_hum_q     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TEMP:    cal_temp_q    <= cfg_data_i[47:0];
        CFG_PRESS_A: cal_press_a_q <= cfg_data_i;
        CFG_PRESS_B: cal_press_b_q <= cfg_data_i;
        CFG_MIXED:   cal_mixed_q   <= cfg_data_i[47:0];
        CFG_HUM:     cal_hum_q     <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Valid line, one bit per stage
  logic [NSTG:1] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NSTG-1:1], start_i & ~busy_o};
    end
  end

  // Stage registers, numbered by the stage that loads them
  logic [17:0] a_q;
  logic [16:0] d_q;
  logic [20:0] pn_q [1:9];
  logic [15:0] ah_q [1:6];
  logic [31:0] m1_q, dd_q;
  logic [31:0] tv1_q, m2_q;
  logic [31:0] tfine_q;
  logic [31:0] tc5_q, fine5_q, hv_q;
  logic [32:0] v1_q;
  tf_t         tf_q [6:15];
  logic [63:0] sq_q;
  logic [48:0] pm5_q [6:8];
  logic [48:0] pm2_q [6:8];
  logic [31:0] h5v_q, b0_q, c0_q;
  logic [31:0] x_q [7:11];
  logic [31:0] b_q, c_q, bc_q, e_q, eh_q, g_q;
  pp_t         pp6_q, pp3_q;
  logic [63:0] s6v_q, s3v_q;
  logic [63:0] v2_q, v1c_q;
  pp_t         ppd_q, ppn_q;
  logic [63:0] nna_q, den_full_q;
  logic [63:0] den_q, num_q;
  logic [31:0] xg_q [12:14];
  logic [31:0] ss_q, sh_q, hv15_q;
  side_t       sd_q [0:67];
  logic [63:0] quo_w;
  logic        dz_w;
  pp_t         ppq_q, pp8_q, pp9_q;
  logic [63:0] p_q [79:82];
  logic        dz_q [79:83];
  logic [63:0] p8p_q [80:82];
  logic [63:0] qq_q, w1_q, r_q;
  res_t        res_q;

  // Products that need their full signed width before wrapping
  logic signed [33:0] m1_w, dd_w, ss_w, sh_w;
  logic signed [35:0] m2_w;
  logic signed [65:0] sq_w;
  logic signed [48:0] pm5_w, pm2_w;
  logic signed [43:0] h5v_w;
  logic signed [39:0] b0_w;
  logic signed [40:0] c0_w;
  logic signed [47:0] eh_w;
  logic [31:0]        xs_w, hcl_w;
  logic [63:0]        prs_w;

  assign m1_w  = $signed(a_q) * t2;
  assign dd_w  = $signed(d_q) * $signed(d_q);
  assign m2_w  = $signed(dd_q[31:12]) * t3;
  assign sq_w  = $signed(v1_q) * $signed(v1_q);
  assign pm5_w = $signed(v1_q) * p5;
  assign pm2_w = $signed(v1_q) * p2;
  assign h5v_w = h5 * $signed(hv_q);
  assign b0_w  = $signed(hv_q) * h6;
  assign c0_w  = $signed(hv_q) * $signed({1'b0, h3});
  assign eh_w  = $signed(e_q) * h2;
  assign ss_w  = $signed(xg_q[12][31:15]) * $signed(xg_q[12][31:15]);
  assign sh_w  = $signed(ss_q[31:7]) * $signed({1'b0, h1});
  assign xs_w  = {2'b00, ah_q[6], 14'd0} - {h4, 20'd0} - h5v_q + X_RND;
  assign prs_w = asr64(r_q, 8) + (sx16(p7) << 4);

  // Humidity is floored at zero and capped at 100 %RH.
  always_comb begin
    priority if (hv15_q[31]) begin
      hcl_w = '0;
    end else if (hv15_q > HUM_MAX) begin
      hcl_w = HUM_MAX;
    end else begin
      hcl_w = hv15_q;
    end
  end

  psc_sdiv u_sdiv (
    .clk_i (clk_i),
    .num_i (num_q),
    .den_i (den_q),
    .quo_o (quo_w),
    .dz_o  (dz_w)
  );

  always_ff @(posedge clk_i) begin
    // Temperature
    a_q      <= {1'b0, req_i.adc_temp[19:3]} - {1'b0, t1, 1'b0};
    d_q      <= {1'b0, req_i.adc_temp[19:4]} - {1'b0, t1};
    pn_q[1]  <= PN_FULL - {1'b0, req_i.adc_press};
    ah_q[1]  <= req_i.adc_hum;
    for (int k = 2; k <= 9; k++) pn_q[k] <= pn_q[k-1];
    for (int k = 2; k <= 6; k++) ah_q[k] <= ah_q[k-1];
    m1_q     <= m1_w[31:0];
    dd_q     <= dd_w[31:0];
    tv1_q    <= asr32(m1_q, 11);
    m2_q     <= m2_w[31:0];
    tfine_q  <= tv1_q + asr32(m2_q, 14);
    tc5_q    <= (tfine_q << 2) + tfine_q + TC_RND;
    fine5_q  <= tfine_q;
    v1_q     <= {tfine_q[31], tfine_q} - P_OFS;
    hv_q     <= tfine_q - H_OFS;
    tf_q[6]  <= '{tc: asr32(tc5_q, 8), fine: fine5_q};
    for (int k = 7; k <= 15; k++) tf_q[k] <= tf_q[k-1];

    // Pressure, up to the divider
    sq_q     <= sq_w[63:0];
    pm5_q[6] <= pm5_w;
    pm2_q[6] <= pm2_w;
    for (int k = 7; k <= 8; k++) begin
      pm5_q[k] <= pm5_q[k-1];
      pm2_q[k] <= pm2_q[k-1];
    end
    pp6_q      <= mul64_pp(sq_q, sx16(p6));
    pp3_q      <= mul64_pp(sq_q, sx16(p3));
    s6v_q      <= pp_sum(pp6_q);
    s3v_q      <= pp_sum(pp3_q);
    v2_q       <= s6v_q + ({{15{pm5_q[8][48]}}, pm5_q[8]} << 17) + (sx16(p4) << 35);
    v1c_q      <= V1_BIAS + asr64(s3v_q, 8) + ({{15{pm2_q[8][48]}}, pm2_q[8]} << 12);
    ppd_q      <= mul64_pp(v1c_q, {48'd0, p1});
    nna_q      <= {12'd0, pn_q[9], 31'd0} - v2_q;
    den_full_q <= pp_sum(ppd_q);
    ppn_q      <= mul64_pp(nna_q, P_SCALE);
    den_q      <= asr64(den_full_q, 33);
    num_q      <= pp_sum(ppn_q);

    // Humidity
    h5v_q    <= h5v_w[31:0];
    b0_q     <= b0_w[31:0];
    c0_q     <= c0_w[31:0];
    x_q[7]   <= asr32(xs_w, 15);
    for (int k = 8; k <= 11; k++) x_q[k] <= x_q[k-1];
    b_q      <= asr32(b0_q, 10);
    c_q      <= asr32(c0_q, 11) + C_OFS;
    bc_q     <= b_q * c_q;
    e_q      <= asr32(bc_q, 10) + E_OFS;
    eh_q     <= eh_w[31:0];
    g_q      <= asr32(eh_q + G_RND, 14);
    xg_q[12] <= x_q[11] * g_q;
    for (int k = 13; k <= 14; k++) xg_q[k] <= xg_q[k-1];
    ss_q     <= ss_w[31:0];
    sh_q     <= sh_w[31:0];
    hv15_q   <= xg_q[14] - asr32(sh_q, 4);
    sd_q[0]  <= '{tc: tf_q[15].tc, fine: tf_q[15].fine, hum: hcl_w[28:12]};
    for (int k = 1; k <= 67; k++) sd_q[k] <= sd_q[k-1];

    // Pressure, after the divider
    p_q[79]   <= quo_w;
    dz_q[79]  <= dz_w;
    ppq_q     <= mul64_pp(asr64(quo_w, 13), asr64(quo_w, 13));
    pp8_q     <= mul64_pp(quo_w, sx16(p8));
    for (int k = 80; k <= 82; k++) p_q[k] <= p_q[k-1];
    for (int k = 80; k <= 83; k++) dz_q[k] <= dz_q[k-1];
    qq_q      <= pp_sum(ppq_q);
    p8p_q[80] <= pp_sum(pp8_q);
    for (int k = 81; k <= 82; k++) p8p_q[k] <= p8p_q[k-1];
    pp9_q     <= mul64_pp(qq_q, sx16(p9));
    w1_q      <= pp_sum(pp9_q);
    r_q       <= p_q[82] + asr64(w1_q, 25) + asr64(p8p_q[82], 19);

    res_q.temp_centi     <= sd_q[67].tc;
    res_q.fine_temp      <= sd_q[67].fine;
    res_q.hum_q10        <= sd_q[67].hum;
    res_q.press_q8       <= dz_q[83] ? 32'd0 : prs_w[31:0];
    res_q.press_div_zero <= dz_q[83];
  end

  assign res_valid_o = vld_q[NSTG];
  assign res_o       = res_q;

  // Every result strobe belongs to a reading taken exactly one latency earlier.
  a_res_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start_i && !busy_o, NSTG))
    else $error("result strobe without a matching reading");

  a_dz_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.press_div_zero) |-> (res_o.press_q8 == 32'd0))
    else $error("pressure not forced to zero on a zero divisor");

  a_hum_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.hum_q10 <= HUM_OUT_MAX))
    else $error("humidity above its clamp");

  a_cfg_wr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && (cfg_index_i == CFG_TEMP))
      |=> (cal_temp_q == $past(cfg_data_i[47:0])))
    else $error("temperature calibration transfer not stored");

endmodule
`default_nettype wire
